// ===== hw/rtl/cbtd_pkg.sv =====
package cbtd_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  localparam logic [3:0] EV_SCALAR       = 4'd0;
  localparam logic [3:0] EV_STR_BYTE     = 4'd1;
  localparam logic [3:0] EV_STR_EMPTY    = 4'd2;
  localparam logic [3:0] EV_STRUCT_BEGIN = 4'd3;
  localparam logic [3:0] EV_STRUCT_END   = 4'd4;
  localparam logic [3:0] EV_LIST_BEGIN   = 4'd5;
  localparam logic [3:0] EV_LIST_END     = 4'd6;
  localparam logic [3:0] EV_DONE         = 4'd7;
  localparam logic [3:0] EV_ERROR        = 4'd8;

  localparam logic [3:0] T_STOP   = 4'd0;
  localparam logic [3:0] T_TRUE   = 4'd1;
  localparam logic [3:0] T_FALSE  = 4'd2;
  localparam logic [3:0] T_BYTE   = 4'd3;
  localparam logic [3:0] T_I16    = 4'd4;
  localparam logic [3:0] T_I32    = 4'd5;
  localparam logic [3:0] T_I64    = 4'd6;
  localparam logic [3:0] T_DOUBLE = 4'd7;
  localparam logic [3:0] T_BINARY = 4'd8;
  localparam logic [3:0] T_LIST   = 4'd9;
  localparam logic [3:0] T_SET    = 4'd10;
  localparam logic [3:0] T_MAP    = 4'd11;
  localparam logic [3:0] T_STRUCT = 4'd12;
  localparam logic [3:0] NIB_LONG = 4'hF;

  localparam logic [2:0] E_TRUNC    = 3'd1;
  localparam logic [2:0] E_VARINT   = 3'd2;
  localparam logic [2:0] E_FTYPE    = 3'd3;
  localparam logic [2:0] E_LTYPE    = 3'd4;
  localparam logic [2:0] E_NEGLEN   = 3'd5;
  localparam logic [2:0] E_TOOLONG  = 3'd6;
  localparam logic [2:0] E_OVERFLOW = 3'd7;

  localparam logic [3:0] VARINT_MAX = 4'd10;

  typedef enum logic [2:0] {
    PH_HEADER, PH_FIDVAR, PH_VARINT, PH_BYTE, PH_DOUBLE, PH_STRING, PH_LISTHDR, PH_STOPPED
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_BEGIN, ST_PUSH, ST_FINVAR, ST_POP, ST_ADVANCE, ST_FINISH, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic        is_list;
    logic [63:0] index;
    logic [3:0]  elem_type;
    logic [31:0] count;
  } frame_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [3:0]  vt;
    logic [63:0] fid;
    logic [63:0] pay;
    logic [3:0]  et;
    logic [2:0]  err;
  } res_t;

  function automatic res_t mk_res(logic [3:0] ev, logic [3:0] vt, logic [63:0] fid,
                                  logic [63:0] pay, logic [3:0] et, logic [2:0] err);
    res_t r;
    r.ev  = ev;
    r.vt  = vt;
    r.fid = fid;
    r.pay = pay;
    r.et  = et;
    r.err = err;
    return r;
  endfunction

  function automatic logic [63:0] unzigzag(logic [63:0] u, logic [3:0] t);
    logic [15:0] v16;
    logic [31:0] v32;
    logic [63:0] v64;
    v16 = (u[15:0] >> 1) ^ {16{u[0]}};
    v32 = (u[31:0] >> 1) ^ {32{u[0]}};
    v64 = (u >> 1) ^ {64{u[0]}};
    case (t)
      T_I16:   return {{48{v16[15]}}, v16};
      T_I32:   return {{32{v32[31]}}, v32};
      default: return v64;
    endcase
  endfunction

endpackage

// ===== hw/rtl/cbtd_frame_ram.sv =====
module cbtd_frame_ram import cbtd_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  frame_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output frame_t        rdata
);

  frame_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/compact_binary_token_decoder.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_ready     data_byte, end_of_data
// out       out_valid / out_ready   event_res .. depth, last
// cfg       cfg_valid / cfg_ready   cfg_data (max_string_len)
//
// Each byte passes at least through accept, decode, truncation check and final flush.
// Further decode steps may follow, and closing a frame passes through a pop state, since the
// frame below is read back from the registered output of the frame memory.
// Results wait in a holding register so the last flag is known; a stalled output stalls
// decoding. Reset is synchronous and needs no clearing pass.
module compact_binary_token_decoder import cbtd_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int SP_W = $clog2(STACK_DEPTH) + 1,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         event_res,
  output logic [3:0]         value_type,
  output logic signed [63:0] field_id,
  output logic signed [63:0] payload,
  output logic [3:0]         element_type,
  output logic [2:0]         error_code,
  output logic [SP_W-1:0]    depth,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [7:0] b;
  logic eod;
  logic [63:0] acc, acc_next;
  logic [3:0] bc, bc_next;
  logic [3:0] pending, pending_next;
  logic [15:0] left, left_next;
  logic [3:0] hold_et, hold_et_next;
  logic [63:0] prev, prev_next;
  logic [SP_W-1:0] sp, sp_next;
  frame_t top, top_next;
  logic [3:0] begin_type, begin_type_next;
  logic [3:0] push_et, push_et_next;
  logic [31:0] push_n, push_n_next;
  logic [3:0] pop_ev, pop_ev_next;
  logic [3:0] pop_vt, pop_vt_next;
  logic [15:0] max_len;

  res_t hold_res, out_res, put_res;
  logic [SP_W-1:0] hold_depth, out_depth, put_depth;
  logic hold_valid, out_last;
  logic put_en, flush_en, out_free, can_put;

  logic mem_we, mem_re;
  frame_t mem_rdata;
  logic [SP_W-1:0] sp_m1;

  logic [6:0] vshift;
  logic [63:0] acc_feed, acc_dbl;
  logic [3:0] bc_inc;
  logic [31:0] len;

  cbtd_frame_ram #(.STACK_DEPTH(STACK_DEPTH)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(sp[AW-1:0]),
    .wdata(top),
    .re   (mem_re),
    .raddr(sp_m1[AW-1:0]),
    .rdata(mem_rdata)
  );

  assign sp_m1 = sp - 1'b1;
  assign out_free = !out_valid || out_ready;
  assign can_put = !hold_valid || out_free;
  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign vshift = {bc, 3'b000} - {3'b000, bc};
  assign acc_feed = acc | ({57'd0, b[6:0]} << vshift);
  assign acc_dbl = acc | ({56'd0, b} << {bc[2:0], 3'b000});
  assign bc_inc = bc + 4'd1;
  assign len = acc[31:0];

  always_comb begin
    state_next = state;
    phase_next = phase;
    acc_next = acc;
    bc_next = bc;
    pending_next = pending;
    left_next = left;
    hold_et_next = hold_et;
    prev_next = prev;
    sp_next = sp;
    top_next = top;
    begin_type_next = begin_type;
    push_et_next = push_et;
    push_n_next = push_n;
    pop_ev_next = pop_ev;
    pop_vt_next = pop_vt;
    put_en = 1'b0;
    put_res = '0;
    flush_en = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (can_put) begin
          case (phase)
            PH_HEADER: begin
              if (b[3:0] == T_STOP) begin
                if (sp == '0) begin
                  put_en = 1'b1;
                  put_res = mk_res(EV_DONE, T_STOP, 64'd0, 64'd0, 4'd0, 3'd0);
                  phase_next = PH_STOPPED;
                  state_next = ST_FINISH;
                end else begin
                  mem_re = 1'b1;
                  pop_ev_next = EV_STRUCT_END;
                  pop_vt_next = T_STOP;
                  state_next = ST_POP;
                end
              end else if (b[3:0] > T_STRUCT || b[3:0] == T_SET || b[3:0] == T_MAP) begin
                put_en = 1'b1;
                put_res = mk_res(EV_ERROR, b[3:0], prev, 64'd0, 4'd0, E_FTYPE);
                phase_next = PH_STOPPED;
                state_next = ST_FINISH;
              end else begin
                pending_next = b[3:0];
                if (b[7:4] == 4'd0) begin
                  acc_next = '0;
                  bc_next = '0;
                  phase_next = PH_FIDVAR;
                  state_next = ST_FINISH;
                end else begin
                  prev_next = prev + {60'd0, b[7:4]};
                  top_next.index = prev_next;
                  begin_type_next = b[3:0];
                  state_next = ST_BEGIN;
                end
              end
            end
            PH_FIDVAR, PH_VARINT: begin
              acc_next = acc_feed;
              bc_next = bc_inc;
              if (!b[7]) begin
                if (phase == PH_FIDVAR) begin
                  prev_next = unzigzag(acc_feed, T_I64);
                  top_next.index = prev_next;
                  begin_type_next = pending;
                  state_next = ST_BEGIN;
                end else begin
                  state_next = ST_FINVAR;
                end
              end else if (bc_inc >= VARINT_MAX) begin
                put_en = 1'b1;
                put_res = mk_res(EV_ERROR, pending, prev, 64'd0, 4'd0, E_VARINT);
                phase_next = PH_STOPPED;
                state_next = ST_FINISH;
              end else begin
                state_next = ST_FINISH;
              end
            end
            PH_BYTE: begin
              put_en = 1'b1;
              put_res = mk_res(EV_SCALAR, T_BYTE, prev, {56'd0, b}, 4'd0, 3'd0);
              state_next = ST_ADVANCE;
            end
            PH_DOUBLE: begin
              acc_next = acc_dbl;
              bc_next = bc_inc;
              if (bc_inc >= 4'd8) begin
                put_en = 1'b1;
                put_res = mk_res(EV_SCALAR, T_DOUBLE, prev, acc_dbl, 4'd0, 3'd0);
                state_next = ST_ADVANCE;
              end else begin
                state_next = ST_FINISH;
              end
            end
            PH_STRING: begin
              put_en = 1'b1;
              put_res = mk_res(EV_STR_BYTE, T_BINARY, prev, {56'd0, b}, 4'd0, 3'd0);
              left_next = left - 16'd1;
              state_next = (left_next == '0) ? ST_ADVANCE : ST_FINISH;
            end
            PH_LISTHDR: begin
              if (b[3:0] < T_BYTE || b[3:0] > T_STRUCT) begin
                put_en = 1'b1;
                put_res = mk_res(EV_ERROR, T_LIST, prev, 64'd0, b[3:0], E_LTYPE);
                phase_next = PH_STOPPED;
                state_next = ST_FINISH;
              end else if (b[7:4] == NIB_LONG) begin
                hold_et_next = b[3:0];
                pending_next = T_LIST;
                acc_next = '0;
                bc_next = '0;
                phase_next = PH_VARINT;
                state_next = ST_FINISH;
              end else begin
                push_et_next = b[3:0];
                push_n_next = {28'd0, b[7:4]};
                state_next = ST_PUSH;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_BEGIN: begin
        if (can_put) begin
          pending_next = begin_type;
          acc_next = '0;
          bc_next = '0;
          state_next = ST_FINISH;
          case (begin_type)
            T_TRUE, T_FALSE: begin
              put_en = 1'b1;
              put_res = mk_res(EV_SCALAR, begin_type, prev,
                               {63'd0, begin_type == T_TRUE}, 4'd0, 3'd0);
              state_next = ST_ADVANCE;
            end
            T_BYTE: phase_next = PH_BYTE;
            T_I16, T_I32, T_I64, T_BINARY: phase_next = PH_VARINT;
            T_DOUBLE: phase_next = PH_DOUBLE;
            T_LIST: phase_next = PH_LISTHDR;
            T_STRUCT: begin
              put_en = 1'b1;
              if (sp == SP_W'(STACK_DEPTH - 1)) begin
                put_res = mk_res(EV_ERROR, T_STRUCT, prev, 64'd0, 4'd0, E_OVERFLOW);
                phase_next = PH_STOPPED;
              end else begin
                mem_we = 1'b1;
                sp_next = sp + 1'b1;
                top_next = '0;
                put_res = mk_res(EV_STRUCT_BEGIN, T_STRUCT, prev, 64'd0, 4'd0, 3'd0);
                prev_next = '0;
                phase_next = PH_HEADER;
              end
            end
            default: begin
              put_en = 1'b1;
              put_res = mk_res(EV_ERROR, begin_type, prev, 64'd0, 4'd0, E_FTYPE);
              phase_next = PH_STOPPED;
            end
          endcase
        end
      end
      ST_PUSH: begin
        if (can_put) begin
          put_en = 1'b1;
          if (sp == SP_W'(STACK_DEPTH - 1)) begin
            put_res = mk_res(EV_ERROR, T_LIST, prev, 64'd0, push_et, E_OVERFLOW);
            phase_next = PH_STOPPED;
            state_next = ST_FINISH;
          end else begin
            mem_we = 1'b1;
            sp_next = sp + 1'b1;
            top_next.is_list = 1'b1;
            top_next.index = '0;
            top_next.elem_type = push_et;
            top_next.count = push_n;
            put_res = mk_res(EV_LIST_BEGIN, T_LIST, prev, {32'd0, push_n}, push_et, 3'd0);
            state_next = ST_ADVANCE;
          end
        end
      end
      ST_FINVAR: begin
        if (can_put) begin
          state_next = ST_FINISH;
          case (pending)
            T_I16, T_I32, T_I64: begin
              put_en = 1'b1;
              put_res = mk_res(EV_SCALAR, pending, prev, unzigzag(acc, pending), 4'd0, 3'd0);
              state_next = ST_ADVANCE;
            end
            T_BINARY: begin
              if (len[31]) begin
                put_en = 1'b1;
                put_res = mk_res(EV_ERROR, T_BINARY, prev, 64'd0, 4'd0, E_NEGLEN);
                phase_next = PH_STOPPED;
              end else if (len >= {16'd0, max_len}) begin
                put_en = 1'b1;
                put_res = mk_res(EV_ERROR, T_BINARY, prev, 64'd0, 4'd0, E_TOOLONG);
                phase_next = PH_STOPPED;
              end else if (len == '0) begin
                put_en = 1'b1;
                put_res = mk_res(EV_STR_EMPTY, T_BINARY, prev, 64'd0, 4'd0, 3'd0);
                state_next = ST_ADVANCE;
              end else begin
                left_next = len[15:0];
                phase_next = PH_STRING;
              end
            end
            default: begin
              if (len[31]) begin
                put_en = 1'b1;
                put_res = mk_res(EV_ERROR, T_LIST, prev, 64'd0, hold_et, E_NEGLEN);
                phase_next = PH_STOPPED;
              end else begin
                push_et_next = hold_et;
                push_n_next = len;
                state_next = ST_PUSH;
              end
            end
          endcase
        end
      end
      ST_POP: begin
        if (can_put) begin
          top_next = mem_rdata;
          sp_next = sp_m1;
          prev_next = mem_rdata.is_list ? mem_rdata.index - 64'd1 : mem_rdata.index;
          put_en = 1'b1;
          put_res = mk_res(pop_ev, pop_vt, prev_next, 64'd0, 4'd0, 3'd0);
          state_next = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (phase == PH_STOPPED) begin
          state_next = ST_FINISH;
        end else if (!top.is_list) begin
          phase_next = PH_HEADER;
          state_next = ST_FINISH;
        end else if (top.index >= {32'd0, top.count}) begin
          mem_re = 1'b1;
          pop_ev_next = EV_LIST_END;
          pop_vt_next = T_LIST;
          state_next = ST_POP;
        end else begin
          prev_next = top.index;
          top_next.index = top.index + 64'd1;
          begin_type_next = top.elem_type;
          state_next = ST_BEGIN;
        end
      end
      ST_FINISH: begin
        if (eod && phase != PH_STOPPED) begin
          if (can_put) begin
            put_en = 1'b1;
            put_res = mk_res(EV_ERROR, T_STOP, prev, 64'd0, 4'd0, E_TRUNC);
            phase_next = PH_STOPPED;
            state_next = ST_FLUSH;
          end
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          flush_en = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    put_depth = sp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_HEADER;
      acc <= '0;
      bc <= '0;
      pending <= '0;
      left <= '0;
      hold_et <= '0;
      prev <= '0;
      sp <= '0;
      top <= '0;
      max_len <= MAX_LEN_RESET;
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      acc <= acc_next;
      bc <= bc_next;
      pending <= pending_next;
      left <= left_next;
      hold_et <= hold_et_next;
      prev <= prev_next;
      sp <= sp_next;
      top <= top_next;
      if (cfg_valid && cfg_ready) begin
        max_len <= cfg_data;
      end
      if (flush_en || (put_en && hold_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (put_en) begin
        hold_valid <= 1'b1;
      end
      if (flush_en) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    begin_type <= begin_type_next;
    push_et <= push_et_next;
    push_n <= push_n_next;
    pop_ev <= pop_ev_next;
    pop_vt <= pop_vt_next;
    if (state == ST_IDLE && in_valid) begin
      b <= data_byte;
      eod <= end_of_data;
    end
    if (put_en) begin
      hold_res <= put_res;
      hold_depth <= put_depth;
      if (hold_valid) begin
        out_res <= hold_res;
        out_depth <= hold_depth;
        out_last <= 1'b0;
      end
    end
    if (flush_en) begin
      out_res <= hold_res;
      out_depth <= hold_depth;
      out_last <= 1'b1;
    end
  end

  assign event_res = out_res.ev;
  assign value_type = out_res.vt;
  assign field_id = out_res.fid;
  assign payload = out_res.pay;
  assign element_type = out_res.et;
  assign error_code = out_res.err;
  assign depth = out_depth;
  assign last = out_last;

endmodule
